[rtl/cbse_pkg.sv]
// Package: shared types, constants and codes of the cubic Bezier spline evaluator.
`default_nettype none
package cbse_pkg;

   localparam int MAX_ANCHORS = 64;
   localparam int T_FRAC_BITS = 12;
   localparam int COORD_BITS  = 16;
   localparam int T_BITS      = 18;

   localparam int SEG_BITS    = T_BITS - T_FRAC_BITS;
   localparam int FRAC_W      = T_FRAC_BITS + 1;
   localparam int ONE         = 1 << T_FRAC_BITS;
   localparam int COUNT_BITS  = $clog2(MAX_ANCHORS + 1);
   localparam int CMP_BITS    = ((SEG_BITS > COUNT_BITS) ? SEG_BITS : COUNT_BITS) + 2;

   // Anchors and control points are each split into an even and an odd bank,
   // so every segment reads one entry per bank.
   localparam int ABANK_DEPTH = (MAX_ANCHORS + 1) / 2;
   localparam int ABANK_AW    = (ABANK_DEPTH > 1) ? $clog2(ABANK_DEPTH) : 1;
   localparam int CBANK_DEPTH = MAX_ANCHORS - 1;
   localparam int CBANK_AW    = (CBANK_DEPTH > 1) ? $clog2(CBANK_DEPTH) : 1;

   localparam int SQ_BITS     = 2 * FRAC_W;
   localparam int CUBE_BITS   = 3 * FRAC_W + 2;
   localparam int WGT_BITS    = 3 * T_FRAC_BITS + 1;
   localparam int TERM_BITS   = COORD_BITS + WGT_BITS + 1;
   localparam int SUM_BITS    = TERM_BITS + 2;
   localparam int RES_SHIFT   = 3 * T_FRAC_BITS;

   typedef enum logic [1:0] {
      ACT_ANCHOR  = 2'd0,
      ACT_CONTROL = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_EVAL    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_ANCHOR_FULL  = 2'd1,
      ST_CONTROL_FULL = 2'd2,
      ST_SEG_UNAVAIL  = 2'd3
   } status_type;

   typedef struct packed {
      action_type                   action;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic [T_BITS-1:0]            param_t;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef logic [FRAC_W-1:0] frac_type;

   // Stage 1: decoded word plus raw bank reads.
   typedef struct packed {
      status_type status;
      logic       ok;
      logic       odd;
      frac_type   u;
      frac_type   v;
      point_type  ae;
      point_type  ao;
      point_type  ce;
      point_type  co;
   } s1_type;

   // Points of the segment in curve order, carried beside the basis math.
   typedef struct packed {
      status_type status;
      logic       ok;
      point_type  p0;
      point_type  c0;
      point_type  c1;
      point_type  p1;
   } tag_type;

   typedef struct packed {
      tag_type               tag;
      logic [WGT_BITS-1:0]   w0;
      logic [WGT_BITS-1:0]   w1;
      logic [WGT_BITS-1:0]   w2;
      logic [WGT_BITS-1:0]   w3;
   } s3_type;

endpackage
`default_nettype wire

[rtl/cbse_store.sv]
// Point stores, counts, word decode and bank reads (pipeline stage 1).
`default_nettype none
module cbse_store (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            take,
   input  wire cbse_pkg::req_type req_word,
   output logic                 s1_valid,
   output cbse_pkg::s1_type     s1
);
   import cbse_pkg::*;

   point_type mem_ae [ABANK_DEPTH];
   point_type mem_ao [ABANK_DEPTH];
   point_type mem_ce [CBANK_DEPTH];
   point_type mem_co [CBANK_DEPTH];

   logic [COUNT_BITS-1:0] anchor_count_ff, anchor_count_in;
   logic [COUNT_BITS-1:0] control_count_ff, control_count_in;
   logic                  valid_ff, valid_in;
   s1_type                s1_ff;

   logic                  accept;
   logic                  small_t;
   logic [SEG_BITS-1:0]   seg;
   frac_type              u;
   frac_type              v;
   logic [CMP_BITS-1:0]   ac, cc, kc;
   logic                  have_two, anchor_room, control_room, seg_ok;
   status_type            status;
   logic                  wr_anchor, wr_control;
   logic [ABANK_AW-1:0]   ae_addr, ao_addr, aw_addr;
   logic [CBANK_AW-1:0]   c_addr, cw_addr;
   point_type             wr_point;

   assign accept = req_valid && take;

   always_comb begin
      small_t = req_word.param_t <= T_BITS'(ONE);
      seg     = small_t ? '0 : req_word.param_t[T_BITS-1:T_FRAC_BITS];
      u       = small_t ? req_word.param_t[FRAC_W-1:0]
                        : {1'b0, req_word.param_t[T_FRAC_BITS-1:0]};
      v       = FRAC_W'(ONE) - u;

      ac = CMP_BITS'(anchor_count_ff);
      cc = CMP_BITS'(control_count_ff);
      kc = CMP_BITS'(seg);
      have_two     = ac >= CMP_BITS'(2);
      anchor_room  = anchor_count_ff < COUNT_BITS'(MAX_ANCHORS);
      control_room = have_two && (cc < ((ac << 1) - CMP_BITS'(2)));
      seg_ok       = have_two && ((kc + CMP_BITS'(1)) < ac)
                     && (((kc << 1) + CMP_BITS'(2)) <= cc);

      status           = ST_OK;
      wr_anchor        = 1'b0;
      wr_control       = 1'b0;
      anchor_count_in  = anchor_count_ff;
      control_count_in = control_count_ff;
      unique case (req_word.action)
         ACT_ANCHOR: begin
            if (anchor_room) begin
               wr_anchor = accept;
            end else begin
               status = ST_ANCHOR_FULL;
            end
         end
         ACT_CONTROL: begin
            if (control_room) begin
               wr_control = accept;
            end else begin
               status = ST_CONTROL_FULL;
            end
         end
         ACT_CLEAR: begin
            if (accept) begin
               anchor_count_in  = '0;
               control_count_in = '0;
            end
         end
         ACT_EVAL: begin
            if (!seg_ok) begin
               status = ST_SEG_UNAVAIL;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (wr_anchor) begin
         anchor_count_in = anchor_count_ff + COUNT_BITS'(1);
      end
      if (wr_control) begin
         control_count_in = control_count_ff + COUNT_BITS'(1);
      end

      // P[k] and P[k+1] sit in opposite banks; odd k swaps them.
      ao_addr  = ABANK_AW'(seg >> 1);
      ae_addr  = ABANK_AW'((seg >> 1) + SEG_BITS'(seg[0]));
      c_addr   = CBANK_AW'(seg);
      aw_addr  = ABANK_AW'(anchor_count_ff >> 1);
      cw_addr  = CBANK_AW'(control_count_ff >> 1);
      wr_point = '{x: req_word.coord_x, y: req_word.coord_y};

      valid_in = take ? req_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff         <= 1'b0;
         anchor_count_ff  <= '0;
         control_count_ff <= '0;
      end else begin
         valid_ff         <= valid_in;
         anchor_count_ff  <= anchor_count_in;
         control_count_ff <= control_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_anchor && !anchor_count_ff[0]) begin
         mem_ae[aw_addr] <= wr_point;
      end
      if (wr_anchor && anchor_count_ff[0]) begin
         mem_ao[aw_addr] <= wr_point;
      end
      if (wr_control && !control_count_ff[0]) begin
         mem_ce[cw_addr] <= wr_point;
      end
      if (wr_control && control_count_ff[0]) begin
         mem_co[cw_addr] <= wr_point;
      end
      if (take) begin
         s1_ff.status <= status;
         s1_ff.ok     <= (req_word.action == ACT_EVAL) && seg_ok;
         s1_ff.odd    <= seg[0];
         s1_ff.u      <= u;
         s1_ff.v      <= v;
         s1_ff.ae     <= mem_ae[ae_addr];
         s1_ff.ao     <= mem_ao[ao_addr];
         s1_ff.ce     <= mem_ce[c_addr];
         s1_ff.co     <= mem_co[c_addr];
      end
   end

   assign s1_valid = valid_ff;
   assign s1       = s1_ff;

endmodule
`default_nettype wire

[rtl/cbse_basis.sv]
// Bernstein weights of the segment parameter (pipeline stages 2 and 3).
`default_nettype none
module cbse_basis (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take2,
   input  wire logic            take3,
   input  wire logic            s1_valid,
   input  wire cbse_pkg::s1_type s1,
   output logic                 s2_valid,
   output logic                 s3_valid,
   output cbse_pkg::s3_type     s3
);
   import cbse_pkg::*;

   logic                 v2_ff, v2_in, v3_ff, v3_in;
   tag_type              tag2_ff, tag2_in;
   frac_type             u_ff, v_ff;
   logic [SQ_BITS-1:0]   uu_ff, vv_ff, uv_ff;
   s3_type               s3_ff, s3_in;
   logic [CUBE_BITS-1:0] vvv, uvv, uuv, uuu;

   always_comb begin
      tag2_in.status = s1.status;
      tag2_in.ok     = s1.ok;
      tag2_in.p0     = s1.odd ? s1.ao : s1.ae;
      tag2_in.p1     = s1.odd ? s1.ae : s1.ao;
      tag2_in.c0     = s1.ce;
      tag2_in.c1     = s1.co;

      vvv = CUBE_BITS'(vv_ff) * CUBE_BITS'(v_ff);
      uvv = CUBE_BITS'(uv_ff) * CUBE_BITS'(v_ff);
      uuv = CUBE_BITS'(uv_ff) * CUBE_BITS'(u_ff);
      uuu = CUBE_BITS'(uu_ff) * CUBE_BITS'(u_ff);

      s3_in.tag = tag2_ff;
      s3_in.w0  = WGT_BITS'(vvv);
      s3_in.w1  = WGT_BITS'(uvv + (uvv << 1));
      s3_in.w2  = WGT_BITS'(uuv + (uuv << 1));
      s3_in.w3  = WGT_BITS'(uuu);

      v2_in = take2 ? s1_valid : v2_ff;
      v3_in = take3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take2) begin
         tag2_ff <= tag2_in;
         u_ff    <= s1.u;
         v_ff    <= s1.v;
         uu_ff   <= SQ_BITS'(s1.u) * SQ_BITS'(s1.u);
         vv_ff   <= SQ_BITS'(s1.v) * SQ_BITS'(s1.v);
         uv_ff   <= SQ_BITS'(s1.u) * SQ_BITS'(s1.v);
      end
      if (take3) begin
         s3_ff <= s3_in;
      end
   end

   assign s2_valid = v2_ff;
   assign s3_valid = v3_ff;
   assign s3       = s3_ff;

endmodule
`default_nettype wire

[rtl/cbse_blend.sv]
// Weighted point products, sum, rounding and the result register (stages 4 and 5).
`default_nettype none
module cbse_blend (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take4,
   input  wire logic            take5,
   input  wire logic            s3_valid,
   input  wire cbse_pkg::s3_type s3,
   output logic                 s4_valid,
   output logic                 rsp_valid,
   output cbse_pkg::rsp_type    rsp_word
);
   import cbse_pkg::*;

   localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1) <<< (RES_SHIFT - 1);

   logic                        v4_ff, v4_in, v5_ff, v5_in;
   status_type                  status4_ff;
   logic                        ok4_ff;
   logic signed [TERM_BITS-1:0] tx_ff [4];
   logic signed [TERM_BITS-1:0] ty_ff [4];
   logic signed [TERM_BITS-1:0] tx_in [4];
   logic signed [TERM_BITS-1:0] ty_in [4];
   logic signed [SUM_BITS-1:0]  sum_x, sum_y;
   rsp_type                     rsp_ff, rsp_in;

   always_comb begin
      tx_in[0] = s3.tag.p0.x * $signed({1'b0, s3.w0});
      tx_in[1] = s3.tag.c0.x * $signed({1'b0, s3.w1});
      tx_in[2] = s3.tag.c1.x * $signed({1'b0, s3.w2});
      tx_in[3] = s3.tag.p1.x * $signed({1'b0, s3.w3});
      ty_in[0] = s3.tag.p0.y * $signed({1'b0, s3.w0});
      ty_in[1] = s3.tag.c0.y * $signed({1'b0, s3.w1});
      ty_in[2] = s3.tag.c1.y * $signed({1'b0, s3.w2});
      ty_in[3] = s3.tag.p1.y * $signed({1'b0, s3.w3});

      // Add one half, then floor by the arithmetic shift.
      sum_x = SUM_BITS'(tx_ff[0]) + SUM_BITS'(tx_ff[1]) + SUM_BITS'(tx_ff[2])
              + SUM_BITS'(tx_ff[3]) + HALF;
      sum_y = SUM_BITS'(ty_ff[0]) + SUM_BITS'(ty_ff[1]) + SUM_BITS'(ty_ff[2])
              + SUM_BITS'(ty_ff[3]) + HALF;

      rsp_in.status  = status4_ff;
      rsp_in.point_x = ok4_ff ? sum_x[RES_SHIFT +: COORD_BITS] : '0;
      rsp_in.point_y = ok4_ff ? sum_y[RES_SHIFT +: COORD_BITS] : '0;

      v4_in = take4 ? s3_valid : v4_ff;
      v5_in = take5 ? v4_ff : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take4) begin
         status4_ff <= s3.tag.status;
         ok4_ff     <= s3.tag.ok;
         tx_ff      <= tx_in;
         ty_ff      <= ty_in;
      end
      if (take5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign s4_valid  = v4_ff;
   assign rsp_valid = v5_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

[rtl/cubic_bezier_spline_evaluator_unit.sv]
// Top level of the piecewise cubic Bezier curve evaluator.
`default_nettype none
// Each request word appends an anchor, appends a control point, clears both
// stores, or evaluates the curve at param_t (12 fractional bits); every word
// answers with exactly one response word, in order. Segment k runs from anchor
// k to anchor k+1 and is shaped by control points 2k and 2k+1; a t up to and
// including 1.0 lands in segment 0, so t = 1.0 returns anchor 1. The evaluated
// point is the exact Bernstein blend rounded to nearest, ties toward plus
// infinity. Throughput is one word per clock when nothing stalls: the block is
// a five-stage pipeline (decode and bank read, squares, weights, products, sum
// and round) whose last stage is the response register, and an accepted word
// passes the decode, squares, weights and products registers before it is
// offered on rsp_valid. Each stage holds while the one after it is full and
// stalled and fills any bubble, so req_ready stays high while a finished
// response waits as long as a stage ahead is empty. Anchors and control points
// each live in an even and an odd bank with one write and one registered read
// port, which is what lets a segment's four points come out together. A point
// appended by one word is visible to the very next word. The stores need no
// clearing pass after reset: only entries below the counts are ever used.
module cubic_bezier_spline_evaluator_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cbse_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cbse_pkg::rsp_type      rsp_word
);
   import cbse_pkg::*;

   logic   s1_valid, s2_valid, s3_valid, s4_valid;
   logic   take1, take2, take3, take4, take5;
   s1_type s1;
   s3_type s3;

   // Advance a stage when it is empty or its contents move on this edge.
   always_comb begin
      take5 = !rsp_valid || rsp_ready;
      take4 = !s4_valid || take5;
      take3 = !s3_valid || take4;
      take2 = !s2_valid || take3;
      take1 = !s1_valid || take2;
   end

   assign req_ready = take1;

   // Decode, update counts, write the banks and read the segment's points.
   cbse_store u_store (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .take      (take1),
      .req_word  (req_word),
      .s1_valid  (s1_valid),
      .s1        (s1)
   );

   // Order the points and build the four weights from u and 1-u.
   cbse_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .take2     (take2),
      .take3     (take3),
      .s1_valid  (s1_valid),
      .s1        (s1),
      .s2_valid  (s2_valid),
      .s3_valid  (s3_valid),
      .s3        (s3)
   );

   // Multiply, sum, round and hold the response word.
   cbse_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .take4     (take4),
      .take5     (take5),
      .s3_valid  (s3_valid),
      .s3        (s3),
      .s4_valid  (s4_valid),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire
